### rtl/scpc_pkg.sv
// Package for the segment / convex polyhedron clip core.
// Holds the fixed-point widths, the bound constants and the sequencer state types.
package scpc_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int T_FRAC_BITS     = 30;
  localparam int COORD_W         = 32;
  localparam int DIR_W           = COORD_W + 1;
  localparam int PROD_W          = COORD_W + DIR_W;
  localparam int ACC_W           = PROD_W + 3;
  localparam int MAG_W           = ACC_W + 3;
  localparam int T_W             = T_FRAC_BITS + 4;
  localparam int Q_W             = T_FRAC_BITS + 3;
  localparam int DIV_STEPS       = T_FRAC_BITS + 3;
  localparam int STEP_W          = $clog2(DIV_STEPS + 1);

  localparam logic signed [T_W-1:0] T_ONE = T_W'(1) << T_FRAC_BITS;
  localparam logic signed [T_W-1:0] T_MAX = (T_W'(1) << Q_W) - T_W'(1);
  localparam logic signed [T_W-1:0] T_MIN = -(T_W'(1) << Q_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHK,
    ST_DIV,
    ST_FIN
  } seq_state_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_CHK,
    DV_RUN
  } div_state_t;

endpackage

### rtl/scpc_if.sv
// Channel interfaces for the clip core: face/segment input and hit output.
// Depends on scpc_pkg for the coordinate width.
interface scpc_in_if import scpc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic signed [COORD_W-1:0] start_x;
  logic signed [COORD_W-1:0] start_y;
  logic signed [COORD_W-1:0] start_z;
  logic signed [COORD_W-1:0] end_x;
  logic signed [COORD_W-1:0] end_y;
  logic signed [COORD_W-1:0] end_z;
  logic signed [COORD_W-1:0] normal_x;
  logic signed [COORD_W-1:0] normal_y;
  logic signed [COORD_W-1:0] normal_z;
  logic signed [COORD_W-1:0] plane_offset;
  logic                      last_face;

  modport source (output valid, kind, start_x, start_y, start_z, end_x, end_y, end_z,
                  normal_x, normal_y, normal_z, plane_offset, last_face, input ready);
  modport sink   (input valid, kind, start_x, start_y, start_z, end_x, end_y, end_z,
                  normal_x, normal_y, normal_z, plane_offset, last_face, output ready);
endinterface

interface scpc_out_if ();
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink   (input valid, hit, output ready);
endinterface

### rtl/scpc_div.sv
// Iterative restoring divider: t = floor(num * 2^T_FRAC_BITS / den), saturated.
// One quotient bit per cycle; depends on scpc_pkg.
module scpc_div import scpc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [ACC_W-1:0] num,
  input  logic signed [ACC_W-1:0] den,
  output logic                    done,
  output logic signed [T_W-1:0]   t
);

  div_state_t              state;
  logic [MAG_W-1:0]        r;
  logic [MAG_W-1:0]        d;
  logic [Q_W-1:0]          q;
  logic                    neg;
  logic [STEP_W-1:0]       step;
  logic [MAG_W-1:0]        cmp;
  logic [MAG_W-1:0]        rs;
  logic                    bit_q;

  always_comb begin
    case (step)
      STEP_W'(0): cmp = d << 2;
      STEP_W'(1): cmp = d << 1;
      default:    cmp = d;
    endcase
    rs    = (step < STEP_W'(3)) ? r : (r << 1);
    bit_q = (rs >= cmp);
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= DV_IDLE;
    end else begin
      case (state)
        DV_IDLE: begin
          if (start) begin
            neg   <= num[ACC_W-1] ^ den[ACC_W-1];
            r     <= num[ACC_W-1] ? MAG_W'(-num) : MAG_W'(num);
            d     <= den[ACC_W-1] ? MAG_W'(-den) : MAG_W'(den);
            state <= DV_CHK;
          end
        end
        DV_CHK: begin
          q    <= '0;
          step <= '0;
          if (r == '0) begin
            t     <= '0;
            done  <= 1'b1;
            state <= DV_IDLE;
          end else if (r >= (d << 3)) begin
            t     <= neg ? T_MIN : T_MAX;
            done  <= 1'b1;
            state <= DV_IDLE;
          end else begin
            state <= DV_RUN;
          end
        end
        DV_RUN: begin
          if (step == STEP_W'(DIV_STEPS)) begin
            if (neg) t <= -T_W'(q) - ((r != '0) ? T_W'(1) : T_W'(0));
            else     t <= T_W'(q);
            done  <= 1'b1;
            state <= DV_IDLE;
          end else begin
            r    <= bit_q ? (rs - cmp) : rs;
            q    <= {q[Q_W-2:0], bit_q};
            step <= step + STEP_W'(1);
          end
        end
        default: state <= DV_IDLE;
      endcase
    end
  end

endmodule

### rtl/segment_convex_polyhedron_clip_core.sv
// Segment against convex polyhedron clip core: top level with sequencer and shared multiplier.
// Depends on scpc_pkg, scpc_if and scpc_div.
//
// A segment transaction loads start and end points in its accept cycle; the block stays ready.
// A face transaction, when the segment has not yet missed, runs from acceptance through six products
// on the one shared 32x33 multiplier with accumulation (ST_MUL), a check state (ST_CHK), the
// iterative divider (T_FRAC_BITS + 3 quotient bits at one per cycle, plus start-up and hand-off)
// (ST_DIV), then the final state (ST_FIN). A divide whose quotient is zero or saturates leaves the
// divider from its check state, and a face parallel to the segment skips the divider.
// Faces after a miss go from acceptance straight to the final state. A face marked last gives
// one hit transaction; input is taken again while that result waits to be collected, unless a
// second result is due.
module segment_convex_polyhedron_clip_core import scpc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  scpc_in_if.sink     in_ch,
  scpc_out_if.source  out_ch
);

  seq_state_t                state, state_next;
  logic signed [COORD_W-1:0] org [3];
  logic signed [DIR_W-1:0]   dir [3];
  logic signed [COORD_W-1:0] nrm [3];
  logic signed [T_W-1:0]     entry_bound;
  logic signed [T_W-1:0]     exit_bound;
  logic                      missed;
  logic                      last;
  logic signed [ACC_W-1:0]   vd;
  logic signed [ACC_W-1:0]   vn;
  logic signed [PROD_W-1:0]  prod;
  logic                      prod_vld;
  logic                      prod_vd;
  logic [2:0]                mi;
  logic                      div_start;
  logic                      div_done;
  logic signed [T_W-1:0]     div_t;
  logic signed [PROD_W-1:0]  op_a;
  logic signed [PROD_W-1:0]  op_b;
  logic signed [T_W-1:0]     entry_next;
  logic signed [T_W-1:0]     exit_next;
  logic                      miss_div;

  scpc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (-vn),
    .den   (vd),
    .done  (div_done),
    .t     (div_t)
  );

  always_comb begin
    case (mi)
      3'd0: begin op_a = PROD_W'(nrm[0]); op_b = PROD_W'(dir[0]); end
      3'd1: begin op_a = PROD_W'(nrm[1]); op_b = PROD_W'(dir[1]); end
      3'd2: begin op_a = PROD_W'(nrm[2]); op_b = PROD_W'(dir[2]); end
      3'd3: begin op_a = PROD_W'(nrm[0]); op_b = PROD_W'(org[0]); end
      3'd4: begin op_a = PROD_W'(nrm[1]); op_b = PROD_W'(org[1]); end
      default: begin op_a = PROD_W'(nrm[2]); op_b = PROD_W'(org[2]); end
    endcase
  end

  always_comb begin
    entry_next = entry_bound;
    exit_next  = exit_bound;
    miss_div   = 1'b0;
    if (!vd[ACC_W-1]) begin
      if (div_t < 0) miss_div = 1'b1;
      else if (div_t < exit_bound) exit_next = div_t;
    end else if (div_t > entry_bound) begin
      entry_next = div_t;
    end
    if (!miss_div && (entry_next > exit_next)) miss_div = 1'b1;
  end

  always_comb begin
    state_next   = state;
    in_ch.ready  = 1'b0;
    div_start    = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          if (!in_ch.kind) state_next = ST_IDLE;
          else if (missed) state_next = ST_FIN;
          else             state_next = ST_MUL;
        end
      end
      ST_MUL: if (mi == 3'd6 && !prod_vld) state_next = ST_CHK;
      ST_CHK: begin
        if (vd == '0) begin
          state_next = ST_FIN;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: if (div_done) state_next = ST_FIN;
      ST_FIN: if (!last || !out_ch.valid || out_ch.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_ch.valid <= 1'b0;
      missed       <= 1'b0;
      entry_bound  <= '0;
      exit_bound   <= T_ONE;
      prod_vld     <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        org[i] <= '0;
        dir[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (out_ch.valid && out_ch.ready && !(state == ST_FIN && last)) out_ch.valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_ch.valid) begin
            last <= in_ch.last_face;
            if (!in_ch.kind) begin
              org[0] <= in_ch.start_x;
              org[1] <= in_ch.start_y;
              org[2] <= in_ch.start_z;
              dir[0] <= DIR_W'(in_ch.end_x) - DIR_W'(in_ch.start_x);
              dir[1] <= DIR_W'(in_ch.end_y) - DIR_W'(in_ch.start_y);
              dir[2] <= DIR_W'(in_ch.end_z) - DIR_W'(in_ch.start_z);
              entry_bound <= '0;
              exit_bound  <= T_ONE;
              missed      <= 1'b0;
            end else begin
              nrm[0]   <= in_ch.normal_x;
              nrm[1]   <= in_ch.normal_y;
              nrm[2]   <= in_ch.normal_z;
              vd       <= '0;
              vn       <= ACC_W'(in_ch.plane_offset) <<< COORD_FRAC_BITS;
              mi       <= 3'd0;
              prod_vld <= 1'b0;
            end
          end
        end
        ST_MUL: begin
          if (mi != 3'd6) begin
            prod     <= op_a * op_b;
            prod_vd  <= (mi < 3'd3);
            prod_vld <= 1'b1;
            mi       <= mi + 3'd1;
          end else begin
            prod_vld <= 1'b0;
          end
          if (prod_vld) begin
            if (prod_vd) vd <= vd + ACC_W'(prod);
            else         vn <= vn + ACC_W'(prod);
          end
        end
        ST_CHK: begin
          if (vd == '0 && !vn[ACC_W-1] && vn != '0) missed <= 1'b1;
        end
        ST_DIV: begin
          if (div_done) begin
            if (miss_div) begin
              missed <= 1'b1;
              if (!vd[ACC_W-1]) begin
                if (!(div_t < 0)) begin
                  entry_bound <= entry_next;
                  exit_bound  <= exit_next;
                end
              end else begin
                entry_bound <= entry_next;
                exit_bound  <= exit_next;
              end
            end else begin
              entry_bound <= entry_next;
              exit_bound  <= exit_next;
            end
          end
        end
        ST_FIN: begin
          if (last && (!out_ch.valid || out_ch.ready)) begin
            out_ch.valid <= 1'b1;
            out_ch.hit   <= !missed;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### tb/scpc_tb_if.sv
`timescale 1ns / 100ps
// Testbench package: the item kind codes and the packed stimulus item type.
// Depends on scpc_pkg; the channel interfaces come from rtl/scpc_if.sv.
package scpc_tb_pkg;
  import scpc_pkg::*;

  typedef enum logic {KIND_SEGMENT = 1'b0, KIND_FACE = 1'b1} item_kind_t;

  typedef struct packed {
    item_kind_t                kind;
    logic signed [COORD_W-1:0] sx, sy, sz, ex, ey, ez;
    logic signed [COORD_W-1:0] nx, ny, nz, w;
    logic                      last_face;
  } clip_item_t;
endpackage

### tb/segment_convex_polyhedron_clip_core_tb.sv
`timescale 1ns / 100ps
// Testbench for segment_convex_polyhedron_clip_core: random and directed segment/face
// transactions, hit results checked against an in-bench clipping predictor.
// Depends on scpc_pkg, scpc_tb_pkg, the scpc interfaces and the RTL top level.
module segment_convex_polyhedron_clip_core_tb;
  import scpc_pkg::*;
  import scpc_tb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #2 clk = ~clk;

  scpc_in_if  in_ch ();
  scpc_out_if out_ch ();

  segment_convex_polyhedron_clip_core dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  clip_item_t pending_items[$];
  logic       expected_hits[$];
  int         fail_count;
  int         hit_count;
  int         result_count;
  int         cycle_count;
  bit         stim_done;
  int         hold_flag;

  logic signed [COORD_W-1:0] org[3];
  logic signed [DIR_W-1:0]   dir[3];
  logic signed [T_W-1:0]     t_entry;
  logic signed [T_W-1:0]     t_exit;
  logic                      missed;

  function automatic void add_item(clip_item_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic logic signed [T_W-1:0] clip_fraction(logic signed [127:0] num,
                                                           logic signed [127:0] den);
    logic         neg;
    logic [127:0] n, d, q;
    logic signed [T_W:0] r;
    neg = num[127] ^ den[127];
    n   = num[127] ? -num : num;
    d   = den[127] ? -den : den;
    if (n == 0) return '0;
    if (n >= (d << 3)) return neg ? T_MIN : T_MAX;
    q = (n << T_FRAC_BITS) / d;
    if (neg) begin
      r = -$signed({1'b0, q[T_W-1:0]});
      if (((n << T_FRAC_BITS) % d) != 0) r = r - 1;
      return r[T_W-1:0];
    end
    return q[T_W-1:0];
  endfunction

  function automatic void predict_reset();
    for (int i = 0; i < 3; i++) begin
      org[i] = '0;
      dir[i] = '0;
    end
    t_entry = '0;
    t_exit  = T_ONE;
    missed  = 1'b0;
  endfunction

  function automatic void predict_item(clip_item_t it);
    logic signed [127:0] vd, vn;
    logic signed [T_W-1:0] t;
    if (it.kind == KIND_SEGMENT) begin
      org[0] = it.sx; org[1] = it.sy; org[2] = it.sz;
      dir[0] = DIR_W'(it.ex) - DIR_W'(it.sx);
      dir[1] = DIR_W'(it.ey) - DIR_W'(it.sy);
      dir[2] = DIR_W'(it.ez) - DIR_W'(it.sz);
      t_entry = '0;
      t_exit  = T_ONE;
      missed  = 1'b0;
      return;
    end
    if (!missed) begin
      vd = 128'(it.nx) * 128'(dir[0]) + 128'(it.ny) * 128'(dir[1]) + 128'(it.nz) * 128'(dir[2]);
      vn = 128'(it.nx) * 128'(org[0]) + 128'(it.ny) * 128'(org[1]) + 128'(it.nz) * 128'(org[2])
           + (128'(it.w) <<< COORD_FRAC_BITS);
      if (vd == 0) begin
        if (vn > 0) missed = 1'b1;
      end else begin
        t = clip_fraction(-vn, vd);
        if (vd > 0) begin
          if (t < 0) missed = 1'b1;
          else if (t < t_exit) t_exit = t;
        end else if (t > t_entry) begin
          t_entry = t;
        end
        if (!missed && t_entry > t_exit) missed = 1'b1;
      end
    end
    if (it.last_face) expected_hits.insert(expected_hits.size(), !missed);
  endfunction

  function automatic clip_item_t make_segment(logic signed [31:0] sx, sy, sz, ex, ey, ez);
    clip_item_t it;
    it = '0;
    it.kind = KIND_SEGMENT;
    it.sx = sx; it.sy = sy; it.sz = sz; it.ex = ex; it.ey = ey; it.ez = ez;
    it.last_face = $urandom_range(0, 1);
    it.nx = $urandom; it.ny = $urandom; it.nz = $urandom; it.w = $urandom;
    return it;
  endfunction

  function automatic clip_item_t make_face(logic signed [31:0] nx, ny, nz, w, logic last);
    clip_item_t it;
    it = '0;
    it.kind = KIND_FACE;
    it.nx = nx; it.ny = ny; it.nz = nz; it.w = w;
    it.last_face = last;
    it.sx = $urandom; it.sy = $urandom; it.sz = $urandom;
    it.ex = $urandom; it.ey = $urandom; it.ez = $urandom;
    return it;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      2: return ($urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000);
      default: return $signed($urandom_range(0, 16)) - 8 <<< 16;
    endcase
  endfunction

  // unit box, +-1 on each axis, faces outward
  function automatic void queue_box_query(logic signed [31:0] sx, sy, sz, ex, ey, ez);
    int order[6];
    add_item(make_segment(sx, sy, sz, ex, ey, ez));
    for (int i = 0; i < 6; i++) order[i] = i;
    order.shuffle();
    for (int i = 0; i < 6; i++) begin
      logic signed [31:0] s;
      s = order[i][0] ? 32'sh0001_0000 : -32'sh0001_0000;
      case (order[i] >> 1)
        0: add_item(make_face(s, 0, 0, -32'sh0001_0000, i == 5));
        1: add_item(make_face(0, s, 0, -32'sh0001_0000, i == 5));
        default: add_item(make_face(0, 0, s, -32'sh0001_0000, i == 5));
      endcase
    end
  endfunction

  // driver
  int in_gap;
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_gap      <= $urandom_range(0, 15);
    end else if (in_ch.valid && !in_ch.ready) begin
    end else if (hold_flag == 1 && (expected_hits.size() != 0 || in_ch.valid)) begin
      in_ch.valid <= 1'b0;
    end else if (in_gap != 0 && !($urandom_range(0, 3) == 0 && cycle_count > 30000)) begin
      in_gap      <= in_gap - 1;
      in_ch.valid <= 1'b0;
    end else if (pending_items.size() != 0 && hold_flag != 2) begin
      clip_item_t it;
      it = pending_items.pop_front();
      if (it.kind == KIND_FACE && it.nx == 32'sh1234_5678) begin
        hold_flag <= 1;
      end
      predict_item(it);
      in_ch.valid        <= 1'b1;
      in_ch.kind         <= it.kind;
      in_ch.start_x      <= it.sx;
      in_ch.start_y      <= it.sy;
      in_ch.start_z      <= it.sz;
      in_ch.end_x        <= it.ex;
      in_ch.end_y        <= it.ey;
      in_ch.end_z        <= it.ez;
      in_ch.normal_x     <= it.nx;
      in_ch.normal_y     <= it.ny;
      in_ch.normal_z     <= it.nz;
      in_ch.plane_offset <= it.w;
      in_ch.last_face    <= it.last_face;
      in_gap             <= (cycle_count % 20000 < 3000) ? 0 : $urandom_range(0, 15);
    end else begin
      in_ch.valid <= 1'b0;
      if (pending_items.size() == 0) stim_done <= 1'b1;
    end
    if (hold_flag == 1 && expected_hits.size() == 0 && !in_ch.valid) hold_flag <= 0;
  end

  // monitor
  int out_gap;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst) begin
      out_ch.ready <= 1'b0;
      out_gap      <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        result_count <= result_count + 1;
        if (expected_hits.size() == 0) begin
          $error("unexpected hit transaction: hit actual %0b", out_ch.hit);
          fail_count <= fail_count + 1;
        end else begin
          logic e;
          e = expected_hits.pop_front();
          if (e) hit_count <= hit_count + 1;
          if (out_ch.hit !== e) begin
            $error("hit mismatch: expected %0b actual %0b", e, out_ch.hit);
            fail_count <= fail_count + 1;
          end
        end
        out_gap <= (cycle_count % 20000 < 3000) ? 0 : $urandom_range(0, 15);
        out_ch.ready <= 1'b0;
      end else if (out_gap != 0) begin
        out_gap      <= out_gap - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = 1'b0;
    {in_ch.start_x, in_ch.start_y, in_ch.start_z} = '0;
    {in_ch.end_x, in_ch.end_y, in_ch.end_z} = '0;
    {in_ch.normal_x, in_ch.normal_y, in_ch.normal_z, in_ch.plane_offset} = '0;
    in_ch.last_face = 1'b0;
    out_ch.ready = 1'b0;
    fail_count = 0; hit_count = 0; result_count = 0; cycle_count = 0;
    stim_done = 1'b0; hold_flag = 0;
    predict_reset();

    // faces before any segment: reset segment at origin, zero length
    add_item(make_face(32'sh0001_0000, 0, 0, -32'sh0001_0000, 1'b1));
    add_item(make_face(32'sh0001_0000, 0, 0, 32'sh0001_0000, 1'b1));
    // miss is sticky, and repeated last faces report again
    add_item(make_face(0, 0, 0, -1, 1'b1));
    queue_box_query(-32'sh0002_0000, 0, 0, 32'sh0002_0000, 0, 0);
    queue_box_query(32'sh0002_0000, 32'sh0002_0000, 0, 32'sh0003_0000, 32'sh0002_0000, 0);
    // zero-length segment inside
    add_item(make_segment(0, 0, 0, 0, 0, 0));
    add_item(make_face(32'sh7fff_ffff, 32'sh8000_0000, 0, 32'sh8000_0000, 1'b0));
    add_item(make_face(32'sh1234_5678, 0, 0, 32'sh8000_0000, 1'b1));
    // extreme endpoints, saturating clip parameter
    add_item(make_segment(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                          32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff));
    add_item(make_face(1, 0, 0, 32'sh7fff_ffff, 1'b0));
    add_item(make_face(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                       32'sh7fff_ffff, 1'b1));
    add_item(make_face(32'shffff_ffff, 32'sh7fff_ffff, 0, 0, 1'b1));

    while (pending_items.size() < 470) begin
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) begin
        queue_box_query($signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000,
                        $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000,
                        $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000,
                        $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000,
                        $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000,
                        $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000);
      end else if (r < 8) begin
        int nf;
        nf = $urandom_range(1, 6);
        add_item(make_segment(rand_coord(), rand_coord(), rand_coord(),
                              rand_coord(), rand_coord(), rand_coord()));
        for (int i = 0; i < nf; i++)
          add_item(make_face(rand_coord(), rand_coord(), rand_coord(),
                             rand_coord(), i == nf - 1));
      end else begin
        add_item(make_face(rand_coord(), rand_coord(), rand_coord(),
                           rand_coord(), $urandom_range(0, 1)));
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    wait (stim_done && expected_hits.size() == 0);
    repeat (200) @(posedge clk);
    $display("covered %0d results (%0d hits) over box queries, random planes and extremes",
             result_count, hit_count);
    if (fail_count == 0) begin
      $display("segment_convex_polyhedron_clip_core regression: pass");
    end else begin
      $display("segment_convex_polyhedron_clip_core regression: fail");
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= 600000);
    $display("segment_convex_polyhedron_clip_core regression: fail");
    $finish;
  end
endmodule
